// ----- rtl/clt_pkg.sv -----
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types, character codes and classifiers for the tokenizer.
// ----------------------------------------------------------------------------
package clt_pkg;

  // Width of a token length, which covers the largest supported limit.
  localparam int unsigned LEN_W = 11;

  // Depth of the result queue in front of the output port.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Character codes that steer the lexer.
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  // Token kinds as they appear on the output.
  typedef enum logic [2:0] {
    KIND_IDENT   = 3'd0,
    KIND_DEC     = 3'd1,
    KIND_STR     = 3'd2,
    KIND_DOLLAR  = 3'd3,
    KIND_EQ      = 3'd4,
    KIND_UNKNOWN = 3'd5,
    KIND_END     = 3'd6,
    KIND_UNTERM  = 3'd7
  } kind_t;

  // One result transaction.
  typedef struct packed {
    kind_t             token_kind;
    logic [7:0]        text_byte;
    logic              has_byte;
    logic              token_done;
    logic [LEN_W-1:0]  token_length;
    logic              length_overflow;
    logic              last_result;
  } result_t;

  // Character classes.
  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) || (c == CH_UNDER);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
  endfunction

endpackage

// ----- rtl/clt_lexer.sv -----
// ----------------------------------------------------------------------------
// clt_lexer
// Lexer state and the one-step transition that turns a byte into results.
// ----------------------------------------------------------------------------
module clt_lexer
  import clt_pkg::*;
#(
  parameter int unsigned WORD_MAX_LEN   = 128,
  parameter int unsigned STRING_MAX_LEN = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  char_in,
  input  logic        end_of_input,
  output result_t     res0,
  output result_t     res1,
  output logic [1:0]  res_count
);

  localparam logic [LEN_W-1:0] WORD_LIM = LEN_W'(WORD_MAX_LEN);
  localparam logic [LEN_W-1:0] STR_LIM  = LEN_W'(STRING_MAX_LEN);

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_IDENT   = 3'd1,
    MODE_DEC     = 3'd2,
    MODE_STR     = 3'd3,
    MODE_COMMENT = 3'd4
  } mode_t;

  // Outcome of handling a byte from idle.
  typedef struct packed {
    logic             emit;
    result_t          res;
    mode_t            mode;
    logic [LEN_W-1:0] count;
  } idle_step_t;

  mode_t            lex_mode, lex_mode_next;
  logic [LEN_W-1:0] text_count, text_count_next;
  logic             overflow_seen, overflow_seen_next;

  result_t          r0, r1;
  logic [1:0]       n;
  idle_step_t       idl;

  function automatic result_t text_result(input kind_t k, input logic [7:0] c);
    result_t r;
    r = '0;
    r.token_kind = k;
    r.text_byte  = c;
    r.has_byte   = 1'b1;
    return r;
  endfunction

  function automatic result_t done_result(input kind_t k, input logic [LEN_W-1:0] len,
                                          input logic ovf);
    result_t r;
    r = '0;
    r.token_kind      = k;
    r.token_done      = 1'b1;
    r.token_length    = len;
    r.length_overflow = ovf;
    return r;
  endfunction

  // A fresh token always has room for its first byte, since every limit is at least one.
  function automatic idle_step_t from_idle(input logic [7:0] c);
    idle_step_t s;
    s       = '0;
    s.mode  = MODE_IDLE;
    if (is_blank(c)) begin
      s.emit = 1'b0;
    end else if (c == CH_HASH) begin
      s.mode = MODE_COMMENT;
    end else if (is_letter(c)) begin
      s.mode  = MODE_IDENT;
      s.count = LEN_W'(1);
      s.emit  = 1'b1;
      s.res   = text_result(KIND_IDENT, c);
    end else if (is_digit(c)) begin
      s.mode  = MODE_DEC;
      s.count = LEN_W'(1);
      s.emit  = 1'b1;
      s.res   = text_result(KIND_DEC, c);
    end else if (c == CH_QUOTE) begin
      s.mode = MODE_STR;
    end else if (c == CH_DOLLAR) begin
      s.emit = 1'b1;
      s.res  = done_result(KIND_DOLLAR, '0, 1'b0);
    end else if (c == CH_EQ) begin
      s.emit = 1'b1;
      s.res  = done_result(KIND_EQ, '0, 1'b0);
    end else begin
      s.emit = 1'b1;
      s.res  = done_result(KIND_UNKNOWN, LEN_W'(1), 1'b0);
      s.res.text_byte = c;
      s.res.has_byte  = 1'b1;
    end
    return s;
  endfunction

  assign idl = from_idle(char_in);

  // Transition for one item: up to two results and the next lexer state.
  always_comb begin
    r0                 = '0;
    r1                 = '0;
    n                  = 2'd0;
    lex_mode_next      = lex_mode;
    text_count_next    = text_count;
    overflow_seen_next = overflow_seen;
    if (end_of_input) begin
      lex_mode_next      = MODE_IDLE;
      text_count_next    = '0;
      overflow_seen_next = 1'b0;
      unique case (lex_mode)
        MODE_IDENT, MODE_DEC, MODE_STR: begin
          r0 = done_result((lex_mode == MODE_IDENT) ? KIND_IDENT :
                           (lex_mode == MODE_DEC)   ? KIND_DEC : KIND_UNTERM,
                           text_count, overflow_seen);
          r1 = done_result(KIND_END, '0, 1'b0);
          n  = 2'd2;
        end
        default: begin
          r0 = done_result(KIND_END, '0, 1'b0);
          n  = 2'd1;
        end
      endcase
    end else begin
      unique case (lex_mode)
        MODE_IDENT, MODE_DEC: begin
          if ((lex_mode == MODE_IDENT) ? is_letter(char_in) : is_digit(char_in)) begin
            if (text_count < WORD_LIM) begin
              text_count_next = text_count + LEN_W'(1);
              r0 = text_result((lex_mode == MODE_IDENT) ? KIND_IDENT : KIND_DEC, char_in);
              n  = 2'd1;
            end else begin
              overflow_seen_next = 1'b1;
            end
          end else begin
            // The terminating byte closes the word and starts over from idle.
            r0 = done_result((lex_mode == MODE_IDENT) ? KIND_IDENT : KIND_DEC,
                             text_count, overflow_seen);
            r1 = idl.res;
            n  = idl.emit ? 2'd2 : 2'd1;
            lex_mode_next      = idl.mode;
            text_count_next    = idl.count;
            overflow_seen_next = 1'b0;
          end
        end
        MODE_STR: begin
          if (char_in == CH_QUOTE) begin
            r0 = done_result(KIND_STR, text_count, overflow_seen);
            n  = 2'd1;
            lex_mode_next      = MODE_IDLE;
            text_count_next    = '0;
            overflow_seen_next = 1'b0;
          end else if (text_count < STR_LIM) begin
            text_count_next = text_count + LEN_W'(1);
            r0 = text_result(KIND_STR, char_in);
            n  = 2'd1;
          end else begin
            overflow_seen_next = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (char_in == CH_NL) begin
            lex_mode_next = MODE_IDLE;
          end
        end
        default: begin
          r0 = idl.res;
          n  = idl.emit ? 2'd1 : 2'd0;
          lex_mode_next      = idl.mode;
          text_count_next    = idl.count;
          overflow_seen_next = 1'b0;
        end
      endcase
    end
  end

  // Mark the final result of the item.
  always_comb begin
    res0             = r0;
    res1             = r1;
    res0.last_result = (n == 2'd1);
    res1.last_result = 1'b1;
    res_count        = n;
  end

  // Lexer state advances once per consumed item.
  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode      <= MODE_IDLE;
      text_count    <= '0;
      overflow_seen <= 1'b0;
    end else if (step) begin
      lex_mode      <= lex_mode_next;
      text_count    <= text_count_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  // End of input always returns the lexer to its reset state.
  a_eof_resets: assert property (@(posedge clk) disable iff (rst)
    (step && end_of_input) |=> (lex_mode == MODE_IDLE && text_count == '0 && !overflow_seen))
    else $error("lexer state not cleared after end of input");

  // Outside a token no length is held, and inside one it never passes its limit.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ((lex_mode == MODE_IDLE || lex_mode == MODE_COMMENT) |-> text_count == '0) and
    ((lex_mode == MODE_IDENT || lex_mode == MODE_DEC) |-> text_count <= WORD_LIM) and
    ((lex_mode == MODE_STR) |-> text_count <= STR_LIM))
    else $error("token length out of range for lexer mode");

endmodule

// ----- rtl/clt_result_queue.sv -----
// ----------------------------------------------------------------------------
// clt_result_queue
// Small result queue: takes up to two results a cycle, gives one a cycle while popped.
// ----------------------------------------------------------------------------
module clt_result_queue
  import clt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  result_t     push0,
  input  result_t     push1,
  input  logic [1:0]  push_n,
  output logic        room_two,
  output result_t     head,
  output logic        head_valid,
  input  logic        pop
);

  result_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic [QPTR_W-1:0]   wr_ptr_1;
  logic                do_pop;

  assign wr_ptr_1   = wr_ptr + QPTR_W'(1);
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_pop     = pop && head_valid;
  assign room_two   = (count <= QCNT_W'(QUEUE_DEPTH - 2));

  // Storage writes; an occupied entry is never overwritten.
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entries[wr_ptr] <= push0;
    end
    if (push_n == 2'd2) begin
      entries[wr_ptr_1] <= push1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push_n);
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push_n) - QCNT_W'(do_pop);
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("result queue overfilled");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push_n == 2'd2 || push_n == 2'd1) |-> room_two)
    else $error("results pushed without room for a full item");

endmodule

// ----- rtl/config_language_tokenizer_top.sv -----
// ----------------------------------------------------------------------------
// config_language_tokenizer_top
// Byte-stream tokenizer for a small configuration language.
//
//   Channel  Direction  Handshake            Payload
//   input    in         in_valid / in_stall   char_in, end_of_input
//   output   out        out_valid / out_stall token_kind, text_byte, has_byte,
//                                             token_done, token_length,
//                                             length_overflow, last_result
//
// An accepted byte is registered, then lexed into zero, one or two result
// transactions that enter a four-entry result queue once it has room for two.
// One byte per cycle is taken while each byte yields at most one result and
// the output is not stalled; a byte that closes a word and starts a new token,
// or an end of input that closes an open token, yields two results, which the
// single output port gives out one at a time, from the head of the queue.
// Reset is synchronous and clears the lexer state and the queue.
// A stalled output fills the queue, then in_stall rises; no data is lost.
// ----------------------------------------------------------------------------
module config_language_tokenizer_top
  import clt_pkg::*;
#(
  parameter int unsigned WORD_MAX_LEN   = 128,
  parameter int unsigned STRING_MAX_LEN = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        char_in,
  input  logic              end_of_input,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        token_kind,
  output logic [7:0]        text_byte,
  output logic              has_byte,
  output logic              token_done,
  output logic [LEN_W-1:0]  token_length,
  output logic              length_overflow,
  output logic              last_result
);

  logic        item_valid;
  logic [7:0]  item_char;
  logic        item_eof;
  logic        fire;
  logic        room_two;
  result_t     res0, res1, head;
  logic [1:0]  res_count;
  logic [1:0]  push_n;

  // Item is lexed when the queue can hold the worst case of two results.
  assign fire     = item_valid && room_two;
  assign in_stall = item_valid && !room_two;
  assign push_n   = fire ? res_count : 2'd0;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_char <= char_in;
      item_eof  <= end_of_input;
    end
  end

  clt_lexer #(
    .WORD_MAX_LEN   (WORD_MAX_LEN),
    .STRING_MAX_LEN (STRING_MAX_LEN)
  ) u_lexer (
    .clk          (clk),
    .rst          (rst),
    .step         (fire),
    .char_in      (item_char),
    .end_of_input (item_eof),
    .res0         (res0),
    .res1         (res1),
    .res_count    (res_count)
  );

  clt_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push0      (res0),
    .push1      (res1),
    .push_n     (push_n),
    .room_two   (room_two),
    .head       (head),
    .head_valid (out_valid),
    .pop        (!out_stall)
  );

  // Output fields from the queue head.
  assign token_kind      = head.token_kind;
  assign text_byte       = head.text_byte;
  assign has_byte        = head.has_byte;
  assign token_done      = head.token_done;
  assign token_length    = head.token_length;
  assign length_overflow = head.length_overflow;
  assign last_result     = head.last_result;

endmodule

// ----- sim/config_language_tokenizer_top_tb.sv -----
// ----------------------------------------------------------------------------
// config_language_tokenizer_top_tb
// Self-checking bench for the byte-stream tokenizer. A directed table and
// then random token streams are sent one byte per transaction; a bit-level
// lexer model in the bench predicts the results, but typed table rows carry
// their own, and a monitor compares each accepted result field by field in
// arrival order. Both channels idle and stall at random, but not in the last phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module config_language_tokenizer_top_tb;
  import clt_pkg::*;

  localparam int WORD_LIMIT   = 128;
  localparam int STRING_LIMIT = 1024;
  localparam int ITEMS_PER_PHASE = 90;

  // Lexer modes of the bench model.
  typedef enum logic [2:0] {
    SCAN_IDLE    = 3'd0,
    SCAN_IDENT   = 3'd1,
    SCAN_DEC     = 3'd2,
    SCAN_STR     = 3'd3,
    SCAN_COMMENT = 3'd4
  } scan_t;

  // One row of the directed stimulus table.
  typedef struct {
    logic [7:0] ch;
    logic       eoi;
    logic       typed;
    result_t    res;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       char_in = 8'h00;
  logic             end_of_input = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [2:0]       token_kind;
  logic [7:0]       text_byte;
  logic             has_byte;
  logic             token_done;
  logic [LEN_W-1:0] token_length;
  logic             length_overflow;
  logic             last_result;

  // Model state and the results still owed by the block.
  scan_t   scan = SCAN_IDLE;
  int      tok_len = 0;
  logic    tok_ovf = 1'b0;
  result_t step_out[$];
  result_t lexed_results[$];
  dir_row_t dir_rows[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int err_count = 0;
  int sent_count = 0;

  config_language_tokenizer_top #(
    .WORD_MAX_LEN   (WORD_LIMIT),
    .STRING_MAX_LEN (STRING_LIMIT)
  ) uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .char_in         (char_in),
    .end_of_input    (end_of_input),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .token_kind      (token_kind),
    .text_byte       (text_byte),
    .has_byte        (has_byte),
    .token_done      (token_done),
    .token_length    (token_length),
    .length_overflow (length_overflow),
    .last_result     (last_result)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Character classes of the language.
  function automatic logic word_char(logic [7:0] c);
    return (c >= CH_LOW_A && c <= CH_LOW_Z) || c == CH_UNDER;
  endfunction

  function automatic logic digit_char(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic blank_char(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_NL;
  endfunction

  function automatic result_t mk(kind_t k, logic [7:0] b, logic hb, logic dn,
                                 logic [LEN_W-1:0] len, logic ov);
    result_t r;
    r.token_kind      = k;
    r.text_byte       = b;
    r.has_byte        = hb;
    r.token_done      = dn;
    r.token_length    = len;
    r.length_overflow = ov;
    r.last_result     = 1'b0;
    return r;
  endfunction

  // Close the open token with its saturated length and overflow flag.
  function automatic void close_tok(kind_t k);
    step_out.push_back(mk(k, 8'h00, 1'b0, 1'b1, LEN_W'(tok_len), tok_ovf));
    tok_len = 0;
    tok_ovf = 1'b0;
    scan    = SCAN_IDLE;
  endfunction

  // Keep a text byte while under the limit; past it, drop it and flag.
  function automatic void add_text(kind_t k, logic [7:0] c, int lim);
    if (tok_len < lim) begin
      tok_len++;
      step_out.push_back(mk(k, c, 1'b1, 1'b0, '0, 1'b0));
    end else begin
      tok_ovf = 1'b1;
    end
  endfunction

  // Handle a byte with no token open.
  function automatic void start_tok(logic [7:0] c);
    tok_len = 0;
    tok_ovf = 1'b0;
    scan    = SCAN_IDLE;
    if (blank_char(c)) begin
    end else if (c == CH_HASH) begin
      scan = SCAN_COMMENT;
    end else if (word_char(c)) begin
      scan = SCAN_IDENT;
      add_text(KIND_IDENT, c, WORD_LIMIT);
    end else if (digit_char(c)) begin
      scan = SCAN_DEC;
      add_text(KIND_DEC, c, WORD_LIMIT);
    end else if (c == CH_QUOTE) begin
      scan = SCAN_STR;
    end else if (c == CH_DOLLAR) begin
      step_out.push_back(mk(KIND_DOLLAR, 8'h00, 1'b0, 1'b1, '0, 1'b0));
    end else if (c == CH_EQ) begin
      step_out.push_back(mk(KIND_EQ, 8'h00, 1'b0, 1'b1, '0, 1'b0));
    end else begin
      step_out.push_back(mk(KIND_UNKNOWN, c, 1'b1, 1'b1, LEN_W'(1), 1'b0));
    end
  endfunction

  // Lex one input transaction into step_out and advance the model state.
  function automatic void lex_byte(logic [7:0] c, logic e);
    step_out.delete();
    if (e) begin
      case (scan)
        SCAN_IDENT: close_tok(KIND_IDENT);
        SCAN_DEC:   close_tok(KIND_DEC);
        SCAN_STR:   close_tok(KIND_UNTERM);
        default:    ;
      endcase
      scan    = SCAN_IDLE;
      tok_len = 0;
      tok_ovf = 1'b0;
      step_out.push_back(mk(KIND_END, 8'h00, 1'b0, 1'b1, '0, 1'b0));
    end else begin
      case (scan)
        SCAN_IDENT: begin
          if (word_char(c)) begin
            add_text(KIND_IDENT, c, WORD_LIMIT);
          end else begin
            close_tok(KIND_IDENT);
            start_tok(c);
          end
        end
        SCAN_DEC: begin
          if (digit_char(c)) begin
            add_text(KIND_DEC, c, WORD_LIMIT);
          end else begin
            close_tok(KIND_DEC);
            start_tok(c);
          end
        end
        SCAN_STR: begin
          if (c == CH_QUOTE) close_tok(KIND_STR);
          else add_text(KIND_STR, c, STRING_LIMIT);
        end
        SCAN_COMMENT: begin
          if (c == CH_NL) scan = SCAN_IDLE;
        end
        default: start_tok(c);
      endcase
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last_result = 1'b1;
  endfunction

  task automatic report_mismatch(string msg);
    if (err_count < 40) $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // Result monitor: each accepted transaction against the oldest prediction.
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (lexed_results.size() == 0) begin
        report_mismatch("result transaction with nothing predicted");
      end else begin
        want = lexed_results.pop_front();
        check_field("token_kind", token_kind, want.token_kind);
        check_field("text_byte", text_byte, want.text_byte);
        check_field("has_byte", has_byte, want.has_byte);
        check_field("token_done", token_done, want.token_done);
        check_field("token_length", token_length, want.token_length);
        check_field("length_overflow", length_overflow, want.length_overflow);
        check_field("last_result", last_result, want.last_result);
      end
    end
  end

  // Send one input transaction; called and returning at a falling edge.
  task automatic send_item(logic [7:0] c, logic e, logic typed, result_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    char_in      <= c;
    end_of_input <= e;
    do @(posedge clk); while (in_stall !== 1'b0);
    lex_byte(c, e);
    if (typed) begin
      lexed_results.push_back(res);
    end else begin
      foreach (step_out[i]) lexed_results.push_back(step_out[i]);
    end
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_byte(logic [7:0] c);
    send_item(c, 1'b0, 1'b0, '0);
  endtask

  // Hold the sender until every predicted result has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    while (lexed_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic void add_row(logic [7:0] ch, logic eoi, logic typed, result_t res);
    dir_row_t r;
    r.ch    = ch;
    r.eoi   = eoi;
    r.typed = typed;
    r.res   = res;
    dir_rows.push_back(r);
  endfunction

  function automatic result_t last_of(result_t r);
    r.last_result = 1'b1;
    return r;
  endfunction

  function automatic logic [7:0] rand_letter();
    int k;
    k = $urandom_range(26);
    return (k == 26) ? CH_UNDER : CH_LOW_A + 8'(k);
  endfunction

  // A string body of the given length, closed unless cut off by end of input.
  task automatic send_string(int len, logic closed);
    logic [7:0] b;
    send_byte(CH_QUOTE);
    repeat (len) begin
      b = 8'($urandom_range(255));
      if (b == CH_QUOTE) b = 8'h21;
      send_byte(b);
    end
    if (closed) send_byte(CH_QUOTE);
    else send_item(8'($urandom_range(255)), 1'b1, 1'b0, '0);
  endtask

  // Random token streams, mostly well formed, with noise mixed in.
  task automatic run_phase(int n_items, logic long_string);
    int start;
    int pick;
    int len;
    logic [7:0] b;
    if (long_string) send_string($urandom_range(STRING_LIMIT - 2, STRING_LIMIT + 3), 1'b1);
    start = sent_count;
    while (sent_count - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(WORD_LIMIT - 3, WORD_LIMIT + 5)
                                        : $urandom_range(1, 8);
        repeat (len) send_byte(rand_letter());
      end else if (pick < 40) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(WORD_LIMIT - 3, WORD_LIMIT + 5)
                                        : $urandom_range(1, 6);
        repeat (len) send_byte(CH_ZERO + 8'($urandom_range(9)));
      end else if (pick < 55) begin
        send_string($urandom_range(12), $urandom_range(9) != 0);
      end else if (pick < 62) begin
        send_byte(CH_DOLLAR);
      end else if (pick < 69) begin
        send_byte(CH_EQ);
      end else if (pick < 77) begin
        case ($urandom_range(2))
          0:       send_byte(CH_SPACE);
          1:       send_byte(CH_TAB);
          default: send_byte(CH_NL);
        endcase
      end else if (pick < 83) begin
        send_byte(CH_HASH);
        repeat ($urandom_range(8)) begin
          b = 8'($urandom_range(255));
          if (b == CH_NL) b = CH_SPACE;
          send_byte(b);
        end
        if ($urandom_range(5) != 0) send_byte(CH_NL);
      end else if (pick < 94) begin
        send_byte(8'($urandom_range(255)));
      end else begin
        send_item(8'($urandom_range(255)), 1'b1, 1'b0, '0);
      end
    end
  endtask

  // Main sequence: reset, directed table, three random phases, final check.
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Symbols, unknown bytes at both ends of the byte range, words that end each
    // other, strings, comments and end of input in idle, number, string and comment.
    add_row(8'hA5, 1'b1, 1'b1,
            last_of(mk(KIND_END, 8'h00, 1'b0, 1'b1, '0, 1'b0)));
    add_row(CH_DOLLAR, 1'b0, 1'b1,
            last_of(mk(KIND_DOLLAR, 8'h00, 1'b0, 1'b1, '0, 1'b0)));
    add_row(CH_EQ, 1'b0, 1'b1,
            last_of(mk(KIND_EQ, 8'h00, 1'b0, 1'b1, '0, 1'b0)));
    add_row(8'h00, 1'b0, 1'b1,
            last_of(mk(KIND_UNKNOWN, 8'h00, 1'b1, 1'b1, LEN_W'(1), 1'b0)));
    add_row(8'hFF, 1'b0, 1'b1,
            last_of(mk(KIND_UNKNOWN, 8'hFF, 1'b1, 1'b1, LEN_W'(1), 1'b0)));
    add_row(CH_LOW_A, 1'b0, 1'b0, '0);
    add_row(CH_LOW_Z, 1'b0, 1'b0, '0);
    add_row(CH_UNDER, 1'b0, 1'b0, '0);
    add_row(CH_ZERO, 1'b0, 1'b0, '0);
    add_row(CH_NINE, 1'b0, 1'b0, '0);
    add_row(CH_EQ, 1'b0, 1'b0, '0);
    add_row(CH_QUOTE, 1'b0, 1'b0, '0);
    add_row(CH_SPACE, 1'b0, 1'b0, '0);
    add_row(CH_HASH, 1'b0, 1'b0, '0);
    add_row(CH_QUOTE, 1'b0, 1'b0, '0);
    add_row(CH_HASH, 1'b0, 1'b0, '0);
    add_row(CH_DOLLAR, 1'b0, 1'b0, '0);
    add_row(CH_NL, 1'b0, 1'b0, '0);
    add_row(CH_TAB, 1'b0, 1'b0, '0);
    add_row(CH_QUOTE, 1'b0, 1'b0, '0);
    add_row(8'h71, 1'b0, 1'b0, '0);
    add_row(8'h5A, 1'b1, 1'b0, '0);
    add_row(CH_NINE, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b0, '0);
    add_row(CH_HASH, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b1, 1'b0, '0);

    send_idle_pct  = 25;
    recv_stall_pct = 74;
    foreach (dir_rows[i]) send_item(dir_rows[i].ch, dir_rows[i].eoi, dir_rows[i].typed,
                                    dir_rows[i].res);
    drain();

    run_phase(ITEMS_PER_PHASE, 1'b1);
    drain();

    send_idle_pct  = 74;
    recv_stall_pct = 25;
    run_phase(ITEMS_PER_PHASE, 1'b0);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_phase(ITEMS_PER_PHASE, 1'b0);
    drain();

    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
